FILE: rtl/core/fsp_pkg.sv
package fsp_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int PULSE_W   = 12;
    localparam int ANGLE_W   = 8;
    localparam int DIFF_W    = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;
    localparam int SPAN_W    = 12;

    localparam int WINDOW_DEF      = 10;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 3'd4;

    localparam logic [PULSE_W-1:0] PULSE_MIN_RST = 12'd500;
    localparam logic [PULSE_W-1:0] PULSE_MAX_RST = 12'd2400;
    localparam logic [ANGLE_W-1:0] ANGLE_MIN_RST = 8'd0;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX_RST = 8'd180;
    localparam logic [PULSE_W-1:0] DEADBAND_RST  = 12'd10;

endpackage

FILE: rtl/core/filtered_servo_pulse_deadband_unit.sv
// One beat at a time: s_ready is high only in idle, so a new beat is taken after
// the previous result is in the output registers. A bit-serial divider for the
// average (SAMPLE_BITS steps), a shift-add multiplier (12 steps) and a divider by
// full scale (12 steps) run one after the other.
// Reset (aresetn, synchronous, active low) restores the register defaults and
// empties the averaging window; the sample memory itself is not cleared.
module filtered_servo_pulse_deadband_unit #(
    parameter int WINDOW      = fsp_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = fsp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [fsp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fsp_pkg::CFG_DAT_W-1:0]     cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [fsp_pkg::SAMPLE_W-1:0]      s_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [fsp_pkg::SAMPLE_W-1:0]      m_filtered,
    output logic [fsp_pkg::PULSE_W-1:0]       m_pulse_us,
    output logic [fsp_pkg::ANGLE_W-1:0]       m_angle_deg,
    output logic                              m_moved,
    output logic signed [fsp_pkg::DIFF_W-1:0] m_pulse_diff
);
    import fsp_pkg::*;

    localparam int SB        = SAMPLE_BITS;
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int SUM_W     = SB + CNT_W;
    localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CMP_W     = (SB > SAMPLE_W) ? SB : SAMPLE_W;
    localparam int LANE_W    = SB + SPAN_W + 1;
    localparam int MAX_STEPS = (SB > SPAN_W) ? SB : SPAN_W;
    localparam int STEP_W    = $clog2(MAX_STEPS);

    localparam logic [SB-1:0]     FULL      = {SB{1'b1}};
    localparam logic [CNT_W-1:0]  WIN_CNT   = CNT_W'(WINDOW);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SB - 1);
    localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(SPAN_W - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ACC  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_MDIV = 3'd4;
    localparam logic [2:0] S_DEAD = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    logic [PULSE_W-1:0]  pmin_reg, pmax_reg, dead_reg;
    logic [ANGLE_W-1:0]  amin_reg, amax_reg;

    logic [SB-1:0]       ring [WINDOW];
    logic [SB-1:0]       old_reg;
    logic [SB-1:0]       samp_reg;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [PULSE_W-1:0]  last_reg;

    logic [SUM_W-1:0]    dv_reg, dv_next;
    logic [LANE_W-1:0]   lp_reg, lp_next;
    logic [LANE_W-1:0]   la_reg, la_next;

    logic                m_valid_reg;
    logic [SAMPLE_W-1:0] filt_reg;
    logic [PULSE_W-1:0]  pulse_out_reg;
    logic [ANGLE_W-1:0]  angle_out_reg;
    logic                moved_reg;
    logic [DIFF_W-1:0]   diff_reg;

    logic [CMP_W-1:0]    s_ext;
    logic [SB-1:0]       s_clamp;
    logic                accept;
    logic                out_free;

    logic [CNT_W:0]      dv_trial;
    logic                dv_take;
    logic [SB-1:0]       avg;
    logic [SPAN_W-1:0]   span_p, span_a;
    logic [SB:0]         lp_add, la_add;
    logic [SB:0]         lp_trial, la_trial;
    logic                lp_take, la_take;

    logic [PULSE_W-1:0]  pulse_val;
    logic [ANGLE_W-1:0]  angle_val;
    logic [DIFF_W-1:0]   raw_diff, abs_diff;
    logic                move_now;

    assign s_ext    = CMP_W'(s_sample);
    assign s_clamp  = (s_ext > CMP_W'(FULL)) ? FULL : SB'(s_ext);
    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign avg    = dv_reg[SB-1:0];
    assign span_p = (pmax_reg >= pmin_reg) ? (pmax_reg - pmin_reg) : '0;
    assign span_a = (amax_reg >= amin_reg) ? SPAN_W'(amax_reg - amin_reg) : '0;

    assign dv_trial = {dv_reg[SUM_W-1 -: CNT_W], dv_reg[SB-1]};
    assign dv_take  = (dv_trial >= {1'b0, fill_reg});

    assign lp_add   = lp_reg[0] ? (lp_reg[LANE_W-1:SPAN_W] + {1'b0, avg})
                                : lp_reg[LANE_W-1:SPAN_W];
    assign la_add   = la_reg[0] ? (la_reg[LANE_W-1:SPAN_W] + {1'b0, avg})
                                : la_reg[LANE_W-1:SPAN_W];
    assign lp_trial = {lp_reg[LANE_W-2 -: SB], lp_reg[SPAN_W-1]};
    assign la_trial = {la_reg[LANE_W-2 -: SB], la_reg[SPAN_W-1]};
    assign lp_take  = (lp_trial >= {1'b0, FULL});
    assign la_take  = (la_trial >= {1'b0, FULL});

    assign pulse_val = pmin_reg + lp_reg[SPAN_W-1:0];
    assign angle_val = amin_reg + la_reg[ANGLE_W-1:0];
    assign raw_diff  = {1'b0, pulse_val} - {1'b0, last_reg};
    assign abs_diff  = raw_diff[DIFF_W-1] ? (~raw_diff + 1'b1) : raw_diff;
    assign move_now  = (abs_diff > {1'b0, dead_reg});

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        sum_next   = sum_reg;
        fill_next  = fill_reg;
        slot_next  = slot_reg;
        dv_next    = dv_reg;
        lp_next    = lp_reg;
        la_next    = la_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                if (fill_reg >= WIN_CNT) begin
                    sum_next = sum_reg - SUM_W'(old_reg) + SUM_W'(samp_reg);
                end else begin
                    sum_next  = sum_reg + SUM_W'(samp_reg);
                    fill_next = fill_reg + 1'b1;
                end
                slot_next  = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                dv_next    = sum_next;
                step_next  = DIV_LAST;
                state_next = S_DIV;
            end
            S_DIV: begin
                dv_next[SUM_W-1 -: CNT_W] = dv_take ? CNT_W'(dv_trial - {1'b0, fill_reg})
                                                    : dv_trial[CNT_W-1:0];
                dv_next[SB-1:0] = {dv_reg[SB-2:0], dv_take};
                step_next = step_reg - 1'b1;
                if (step_reg == '0) begin
                    lp_next    = {{(SB+1){1'b0}}, span_p};
                    la_next    = {{(SB+1){1'b0}}, span_a};
                    step_next  = MUL_LAST;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                lp_next   = {1'b0, lp_add, lp_reg[SPAN_W-1:1]};
                la_next   = {1'b0, la_add, la_reg[SPAN_W-1:1]};
                step_next = step_reg - 1'b1;
                if (step_reg == '0) begin
                    step_next  = MUL_LAST;
                    state_next = S_MDIV;
                end
            end
            S_MDIV: begin
                lp_next = {1'b0, lp_take ? SB'(lp_trial - {1'b0, FULL}) : lp_trial[SB-1:0],
                           lp_reg[SPAN_W-2:0], lp_take};
                la_next = {1'b0, la_take ? SB'(la_trial - {1'b0, FULL}) : la_trial[SB-1:0],
                           la_reg[SPAN_W-2:0], la_take};
                step_next = step_reg - 1'b1;
                if (step_reg == '0) begin
                    state_next = S_DEAD;
                end
            end
            S_DEAD: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            old_reg  <= ring[slot_reg];
            samp_reg <= s_clamp;
        end
        if (state_reg == S_ACC) begin
            ring[slot_reg] <= samp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            sum_reg     <= '0;
            fill_reg    <= '0;
            slot_reg    <= '0;
            last_reg    <= '0;
            m_valid_reg <= 1'b0;
            pmin_reg    <= PULSE_MIN_RST;
            pmax_reg    <= PULSE_MAX_RST;
            amin_reg    <= ANGLE_MIN_RST;
            amax_reg    <= ANGLE_MAX_RST;
            dead_reg    <= DEADBAND_RST;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sum_reg   <= sum_next;
            fill_reg  <= fill_next;
            slot_reg  <= slot_next;
            if (state_reg == S_DEAD && out_free) begin
                m_valid_reg <= 1'b1;
                if (move_now) begin
                    last_reg <= pulse_val;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_PULSE_MIN: pmin_reg <= cfg_wdata[PULSE_W-1:0];
                    REG_PULSE_MAX: pmax_reg <= cfg_wdata[PULSE_W-1:0];
                    REG_ANGLE_MIN: amin_reg <= cfg_wdata[ANGLE_W-1:0];
                    REG_ANGLE_MAX: amax_reg <= cfg_wdata[ANGLE_W-1:0];
                    REG_DEADBAND:  dead_reg <= cfg_wdata[PULSE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        dv_reg <= dv_next;
        lp_reg <= lp_next;
        la_reg <= la_next;
        if (state_reg == S_DEAD && out_free) begin
            filt_reg      <= SAMPLE_W'(avg);
            pulse_out_reg <= pulse_val;
            angle_out_reg <= angle_val;
            moved_reg     <= move_now;
            diff_reg      <= move_now ? '0 : raw_diff;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_filtered   = filt_reg;
    assign m_pulse_us   = pulse_out_reg;
    assign m_angle_deg  = angle_out_reg;
    assign m_moved      = moved_reg;
    assign m_pulse_diff = diff_reg;

endmodule
